>>> design/scsfp_pkg.sv
// ----------------------------------------------------------------------------
// scsfp_pkg
// Shared types, constants and helpers for the sum-checked sensor frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scsfp_pkg;

    // Frame layout.
    localparam logic [7:0] HEADER_BYTE  = 8'h55;
    localparam logic [3:0] POS_IDLE     = 4'd0;
    localparam logic [3:0] POS_TYPE     = 4'd1;
    localparam logic [3:0] POS_CHECKSUM = 4'd10;
    localparam logic [3:0] FRAME_LEN    = 4'd11;

    // Range of record kinds that the block recognises.
    localparam logic [7:0] TYPE_LOW  = 8'h50;
    localparam logic [7:0] TYPE_HIGH = 8'h5A;

    // Default depth of the queue between the assembler and the output stage.
    localparam int QUEUE_DEPTH = 2;

    // One checked frame as it travels through the queue.
    typedef struct packed {
        logic [7:0]  frame_type;
        logic [63:0] payload;
    } t_frame;

    // Write side of the queue.
    typedef struct packed {
        logic   push;
        t_frame frame;
    } t_push;

    // Fill status of the queue.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // True when the type byte lies in the recognised range.
    function automatic logic type_is_known(input logic [7:0] frame_type);
        return (frame_type >= TYPE_LOW) && (frame_type <= TYPE_HIGH);
    endfunction

endpackage

`default_nettype wire

>>> design/scsfp_front.sv
// ----------------------------------------------------------------------------
// scsfp_front
// Accepts received bytes, tracks the frame position, accumulates the sum and
// pushes each frame whose checksum matches into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scsfp_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [7:0]            i_rx_byte,
    input  wire scsfp_pkg::t_q_status  i_q_status,
    output scsfp_pkg::t_push           o_push
);

    logic [3:0]  r_pos,     n_pos;
    logic [7:0]  r_sum,     n_sum;
    logic [7:0]  r_type,    n_type;
    logic [63:0] r_payload, n_payload;
    logic        w_accept;
    logic        w_idle;

    // Only the checksum beat needs room in the queue; other beats never stall.
    assign o_ready  = !((r_pos == scsfp_pkg::POS_CHECKSUM) && i_q_status.full);
    assign w_accept = i_valid && o_ready;
    assign w_idle   = (r_pos == scsfp_pkg::POS_IDLE) || (r_pos >= scsfp_pkg::FRAME_LEN);

    // Next-state logic for the frame assembler. The frame offered to the queue
    // is always the one held in the registers.
    always_comb begin
        n_pos                   = r_pos;
        n_sum                   = r_sum;
        n_type                  = r_type;
        n_payload               = r_payload;
        o_push.push             = 1'b0;
        o_push.frame.frame_type = r_type;
        o_push.frame.payload    = r_payload;
        if (w_accept) begin
            priority if (w_idle) begin
                if (i_rx_byte == scsfp_pkg::HEADER_BYTE) begin
                    n_sum     = i_rx_byte;
                    n_payload = '0;
                    n_pos     = scsfp_pkg::POS_TYPE;
                end else begin
                    n_pos = scsfp_pkg::POS_IDLE;
                end
            end else if (r_pos == scsfp_pkg::POS_TYPE) begin
                n_type = i_rx_byte;
                n_sum  = r_sum + i_rx_byte;
                n_pos  = r_pos + 4'd1;
            end else if (r_pos < scsfp_pkg::POS_CHECKSUM) begin
                n_payload = {i_rx_byte, r_payload[63:8]};
                n_sum     = r_sum + i_rx_byte;
                n_pos     = r_pos + 4'd1;
            end else begin
                n_pos       = scsfp_pkg::POS_IDLE;
                o_push.push = (r_sum == i_rx_byte);
            end
        end
    end

    // Position is control state; the sum, type and payload start afresh with
    // each header but are cleared here too, matching the reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= scsfp_pkg::POS_IDLE;
            r_sum     <= '0;
            r_type    <= '0;
            r_payload <= '0;
        end else begin
            r_pos     <= n_pos;
            r_sum     <= n_sum;
            r_type    <= n_type;
            r_payload <= n_payload;
        end
    end

endmodule

`default_nettype wire

>>> design/scsfp_queue.sv
// ----------------------------------------------------------------------------
// scsfp_queue
// Small first-in first-out queue of checked frames between the assembler and
// the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scsfp_queue #(
    parameter int DEPTH = scsfp_pkg::QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire scsfp_pkg::t_push   i_push,
    input  wire logic               i_pop,
    output scsfp_pkg::t_frame       o_head,
    output scsfp_pkg::t_q_status    o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    scsfp_pkg::t_frame r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic              w_wr;
    logic              w_rd;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == FULL_CNT);
    assign w_wr = i_push.push && !o_status.full;
    assign w_rd = i_pop && !o_status.empty;
    assign o_head = r_mem[r_rd_ptr];

    // Pointer and count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        unique case ({w_wr, w_rd})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset: an entry is read only after it is written.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.frame;
        end
    end

endmodule

`default_nettype wire

>>> design/scsfp_back.sv
// ----------------------------------------------------------------------------
// scsfp_back
// Output stage: takes frames from the queue, classifies the type byte and
// holds the result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scsfp_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire scsfp_pkg::t_frame     i_head,
    input  wire scsfp_pkg::t_q_status  i_q_status,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [7:0]                 o_frame_type,
    output logic [63:0]                o_frame_payload,
    output logic                       o_type_known
);

    logic        r_valid;
    logic [7:0]  r_type;
    logic [63:0] r_payload;
    logic        r_known;
    logic        w_load;

    // Load a new frame when the output register is empty or being emptied.
    assign w_load = !r_valid || i_ready;
    assign o_pop  = w_load && !i_q_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= !i_q_status.empty;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_type    <= i_head.frame_type;
            r_payload <= i_head.payload;
            r_known   <= scsfp_pkg::type_is_known(i_head.frame_type);
        end
    end

    assign o_valid         = r_valid;
    assign o_frame_type    = r_type;
    assign o_frame_payload = r_payload;
    assign o_type_known    = r_known;

endmodule

`default_nettype wire

>>> design/sum_checked_sensor_frame_parser.sv
// ----------------------------------------------------------------------------
// sum_checked_sensor_frame_parser
// Assembles 11-byte sensor frames from a byte stream and emits those whose
// 8-bit sum checks out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready / i_rx_byte) takes one received byte per
//   beat. A frame is header 0x55, a type byte, eight payload bytes and a
//   checksum byte equal to the wrapping sum of the first ten bytes.
//   Output channel (o_valid / i_ready) carries one beat per good frame: the
//   type byte, the payload with the first payload byte in bits 7:0, and a
//   flag for types 0x50 to 0x5A. Bad frames and stray bytes give nothing.
//   Throughput: one byte per cycle, but a checksum byte waits while the queue is full.
//   Result path: the queue is written when the checksum byte is taken, and
//   the output register is loaded from the queue once that register is
//   empty or being emptied.
//   Reset (synchronous, active low) returns the assembler to hunting for a
//   header and empties the queue and the output register.
//   When the receiver stalls, results collect in the queue; data bytes keep
//   flowing, and only a checksum byte waits while the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sum_checked_sensor_frame_parser #(
    parameter int QUEUE_DEPTH = scsfp_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_frame_type,
    output logic [63:0]      o_frame_payload,
    output logic             o_type_known
);

    scsfp_pkg::t_push     w_push;
    scsfp_pkg::t_q_status w_q_status;
    scsfp_pkg::t_frame    w_head;
    logic                 w_pop;

    // Front: byte assembly and checksum.
    scsfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_rx_byte  (i_rx_byte),
        .i_q_status (w_q_status),
        .o_push     (w_push)
    );

    // Queue between the two halves.
    scsfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // Back: output register.
    scsfp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_q_status      (w_q_status),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_frame_type    (o_frame_type),
        .o_frame_payload (o_frame_payload),
        .o_type_known    (o_type_known)
    );

    // A good frame is never pushed into a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push |-> !w_q_status.full)
        else $error("frame pushed into a full queue");

    // The back end never pops an empty queue.
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("pop from an empty queue");

    // The known-type flag agrees with the type byte it travels with.
    a_flag_matches_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_type_known == scsfp_pkg::type_is_known(o_frame_type)))
        else $error("type flag disagrees with frame type");

    // No result is shown in the cycle after reset.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid straight after reset");

endmodule

`default_nettype wire
